>>> design/cccw_pkg.sv
// Shared types, constants and feature-mapping functions for the context window.
`timescale 1ns / 1ps

package cccw_pkg;

    localparam int ROW_W     = 12;
    localparam int BEFORE_W  = 5;
    localparam int AHEAD_W   = 6;
    localparam int TWO_W     = 2;
    localparam int PEND_W    = 2;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = 2;
    localparam int QCNT_W    = 3;

    // Positions of the own-character features inside a row.
    localparam int B_ALPHA   = 0;
    localparam int B_ALNUM   = 1;
    localparam int B_NUMERIC = 2;
    localparam int B_LOWER   = 3;
    localparam int B_UPPER   = 4;
    localparam int B_SPACE   = 5;
    localparam int B_SYMBOL  = 6;
    localparam int B_SPECIAL = 7;
    localparam int B_AT      = 8;
    localparam int B_COLON   = 9;
    localparam int B_SLASH   = 10;
    localparam int B_PERIOD  = 11;

    localparam logic [ROW_W-1:0] SPACE_ROW = ROW_W'(1) << B_SPACE;

    localparam logic [PEND_W-1:0] PEND_FULL = PEND_W'(2);

    typedef logic [ROW_W-1:0] row_t;

    typedef struct packed {
        logic last;
        row_t row;
    } entry_t;

    // Handshake between the queue and the back end.
    typedef struct packed {
        logic   valid;
        entry_t data;
    } q_out_t;

    function automatic logic [BEFORE_W-1:0] before_of(input row_t r);
        before_of = {r[B_SYMBOL], r[B_SPACE], r[B_LOWER], r[B_ALNUM], r[B_ALPHA]};
    endfunction

    function automatic logic [AHEAD_W-1:0] ahead_of(input row_t r);
        ahead_of = {r[B_SLASH], r[B_AT], r[B_SPACE], r[B_LOWER], r[B_ALNUM], r[B_ALPHA]};
    endfunction

    function automatic logic [TWO_W-1:0] two_ahead_of(input row_t r);
        two_ahead_of = {r[B_SLASH], r[B_ALPHA]};
    endfunction

endpackage

>>> design/cccw_front.sv
// Front end: turns the class flags of one character into its own-feature row.
`timescale 1ns / 1ps

module cccw_front
    import cccw_pkg::*;
(
    input  logic   is_alpha,
    input  logic   is_numeric,
    input  logic   is_lower,
    input  logic   is_upper,
    input  logic   is_space,
    input  logic   is_printable,
    input  logic   is_special,
    input  logic   is_at_sign,
    input  logic   is_colon,
    input  logic   is_slash,
    input  logic   is_period,
    input  logic   end_of_text,
    output entry_t entry
);

    logic alnum;
    logic symbol;

    assign alnum  = is_alpha | is_numeric;
    // A symbol is printable, yet neither alphanumeric nor whitespace.
    assign symbol = is_printable & ~alnum & ~is_space;

    always_comb
    begin
        entry.last           = end_of_text;
        entry.row            = '0;
        entry.row[B_ALPHA]   = is_alpha;
        entry.row[B_ALNUM]   = alnum;
        entry.row[B_NUMERIC] = is_numeric;
        entry.row[B_LOWER]   = is_lower;
        entry.row[B_UPPER]   = is_upper;
        entry.row[B_SPACE]   = is_space;
        entry.row[B_SYMBOL]  = symbol;
        entry.row[B_SPECIAL] = is_special;
        entry.row[B_AT]      = is_at_sign;
        entry.row[B_COLON]   = is_colon;
        entry.row[B_SLASH]   = is_slash;
        entry.row[B_PERIOD]  = is_period;
    end

endmodule

>>> design/cccw_queue.sv
// Short queue of classified characters between the front and back ends.
`timescale 1ns / 1ps

module cccw_queue
    import cccw_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr_valid,
    output logic   wr_ready,
    input  entry_t wr_data,
    output q_out_t rd,
    input  logic   rd_pop
);

    entry_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               push;
    logic               pop;

    assign wr_ready = (count_reg != QCNT_W'(QDEPTH));
    assign push     = wr_valid && wr_ready;
    assign rd.valid = (count_reg != '0);
    assign rd.data  = mem_reg[rd_ptr_reg];
    assign pop      = rd_pop && rd.valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> design/cccw_back.sv
// Back end: keeps the three-row window, builds feature rows and flushes at end of text.
`timescale 1ns / 1ps

module cccw_back
    import cccw_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  q_out_t              rd,
    output logic                rd_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [ROW_W-1:0]    own_bits,
    output logic [BEFORE_W-1:0] before_bits,
    output logic [AHEAD_W-1:0]  ahead_bits,
    output logic [TWO_W-1:0]    two_ahead_bits,
    output logic                row_last
);

    localparam logic [1:0] ST_RUN     = 2'd0;
    localparam logic [1:0] ST_FLUSH_B = 2'd1;
    localparam logic [1:0] ST_FLUSH_C = 2'd2;

    logic [1:0]          state_reg, state_next;
    row_t                w0_reg, w0_next;
    row_t                w1_reg, w1_next;
    row_t                w2_reg, w2_next;
    logic [PEND_W-1:0]   pend_reg, pend_next;
    logic                out_valid_reg, out_valid_next;
    row_t                own_reg, own_next;
    logic [BEFORE_W-1:0] before_reg, before_next;
    logic [AHEAD_W-1:0]  ahead_reg, ahead_next;
    logic [TWO_W-1:0]    two_reg, two_next;
    logic                last_reg, last_next;
    logic                out_free;
    logic                load;
    logic                full_window;

    assign out_free    = !out_valid_reg || out_ready;
    assign full_window = (pend_reg >= PEND_FULL);

    always_comb
    begin
        state_next  = state_reg;
        w0_next     = w0_reg;
        w1_next     = w1_reg;
        w2_next     = w2_reg;
        pend_next   = pend_reg;
        own_next    = own_reg;
        before_next = before_reg;
        ahead_next  = ahead_reg;
        two_next    = two_reg;
        last_next   = last_reg;
        load        = 1'b0;
        rd_pop      = 1'b0;

        case (state_reg)
            ST_RUN:
            begin
                if (rd.valid && (!full_window || out_free))
                begin
                    rd_pop = 1'b1;
                    // The middle row becomes complete once its after-next char is known.
                    if (full_window)
                    begin
                        load        = 1'b1;
                        own_next    = w1_reg;
                        before_next = before_of(w2_reg);
                        ahead_next  = ahead_of(w0_reg);
                        two_next    = two_ahead_of(rd.data.row);
                        last_next   = 1'b0;
                    end
                    w2_next   = w1_reg;
                    w1_next   = w0_reg;
                    w0_next   = rd.data.row;
                    pend_next = full_window ? PEND_FULL : pend_reg + 1'b1;
                    if (rd.data.last)
                    begin
                        state_next = (full_window || pend_reg == PEND_W'(1)) ?
                                     ST_FLUSH_B : ST_FLUSH_C;
                    end
                end
            end
            ST_FLUSH_B:
            begin
                if (out_free)
                begin
                    load        = 1'b1;
                    own_next    = w1_reg;
                    before_next = before_of(w2_reg);
                    ahead_next  = ahead_of(w0_reg);
                    two_next    = '0;
                    last_next   = 1'b0;
                    state_next  = ST_FLUSH_C;
                end
            end
            ST_FLUSH_C:
            begin
                if (out_free)
                begin
                    load        = 1'b1;
                    own_next    = w0_reg;
                    before_next = before_of(w1_reg);
                    ahead_next  = ahead_of(SPACE_ROW);
                    two_next    = '0;
                    last_next   = 1'b1;
                    // Back to the start-of-string window.
                    w0_next     = SPACE_ROW;
                    w1_next     = '0;
                    w2_next     = '0;
                    pend_next   = '0;
                    state_next  = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            w0_reg        <= SPACE_ROW;
            w1_reg        <= '0;
            w2_reg        <= '0;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            w0_reg        <= w0_next;
            w1_reg        <= w1_next;
            w2_reg        <= w2_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        own_reg    <= own_next;
        before_reg <= before_next;
        ahead_reg  <= ahead_next;
        two_reg    <= two_next;
        last_reg   <= last_next;
    end

    assign out_valid      = out_valid_reg;
    assign own_bits       = own_reg;
    assign before_bits    = before_reg;
    assign ahead_bits     = ahead_reg;
    assign two_ahead_bits = two_reg;
    assign row_last       = last_reg;

endmodule

>>> design/char_class_context_window.sv
// Top level of the character-class context window feature generator.
`timescale 1ns / 1ps

// Usage: the input channel (in_valid/in_ready) takes one classified character
// per item, its eleven class flags plus end_of_text on the final character.
// The output channel (out_valid/out_ready) gives one feature row per
// character: own features, previous-character, next and after-next features.
// A row is complete only once the two characters after it have arrived, so
// the row of character k leaves after character k+2 is accepted: that item
// is written into the four-entry queue, from which the back end pops it and
// loads the row into the output register once that register is free.
// Throughput is one item per cycle while out_ready stays high; the window
// update in the back end handles one queue entry per cycle. After the final
// character of a string the back end emits up to two further rows in
// sequence from its flush states and pops nothing.
// After reset the window holds the start-of-string state (the previous
// character counts as a space); the same state returns after each flush.
// When the receiver stalls, the output register holds its row, the back end
// stops popping, and the queue fills; in_ready drops only when it is full.
module char_class_context_window
    import cccw_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                is_alpha,
    input  logic                is_numeric,
    input  logic                is_lower,
    input  logic                is_upper,
    input  logic                is_space,
    input  logic                is_printable,
    input  logic                is_special,
    input  logic                is_at_sign,
    input  logic                is_colon,
    input  logic                is_slash,
    input  logic                is_period,
    input  logic                end_of_text,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [ROW_W-1:0]    own_bits,
    output logic [BEFORE_W-1:0] before_bits,
    output logic [AHEAD_W-1:0]  ahead_bits,
    output logic [TWO_W-1:0]    two_ahead_bits,
    output logic                row_last
);

    entry_t front_entry;
    q_out_t q_rd;
    logic   q_pop;

    // Classification happens on the way into the queue.
    cccw_front u_front (
        .is_alpha     (is_alpha),
        .is_numeric   (is_numeric),
        .is_lower     (is_lower),
        .is_upper     (is_upper),
        .is_space     (is_space),
        .is_printable (is_printable),
        .is_special   (is_special),
        .is_at_sign   (is_at_sign),
        .is_colon     (is_colon),
        .is_slash     (is_slash),
        .is_period    (is_period),
        .end_of_text  (end_of_text),
        .entry        (front_entry)
    );

    // The queue lets the input side keep going while the back end flushes.
    cccw_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (in_valid),
        .wr_ready (in_ready),
        .wr_data  (front_entry),
        .rd       (q_rd),
        .rd_pop   (q_pop)
    );

    cccw_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .rd             (q_rd),
        .rd_pop         (q_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .own_bits       (own_bits),
        .before_bits    (before_bits),
        .ahead_bits     (ahead_bits),
        .two_ahead_bits (two_ahead_bits),
        .row_last       (row_last)
    );

endmodule
